// ===== rtl/i2c_master_byte_engine_assert.svh =====
// Assertion macros used by the I2C master phase engine (i2cm_engine).
// The enclosing module must provide clk and rst.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W = 4;
  localparam logic [BIT_CNT_W-1:0] BIT_COUNT_INIT = BIT_CNT_W'(BITS_PER_BYTE);

  // Command codes as they arrive on the cmd port.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // One bus tick as held in the queue between the front and the engine.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       send_nack;
    logic       scl_level;
    logic       sda_level;
  } tick_beat_t;

endpackage

// ===== rtl/i2cm_front.sv =====
module i2cm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          cmd,
  input  logic [7:0]          write_data,
  input  logic                send_nack,
  input  logic                scl_level,
  input  logic                sda_level,
  output logic                beat_valid,
  input  logic                beat_ready,
  output i2cm_pkg::tick_beat_t beat
);
  import i2cm_pkg::*;

  localparam int DEPTH = 2;

  tick_beat_t entries [DEPTH];
  tick_beat_t classified;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // Unused command codes are folded into "no command" on the way in.
  always_comb begin
    classified.write_data = write_data;
    classified.send_nack  = send_nack;
    classified.scl_level  = scl_level;
    classified.sda_level  = sda_level;
    unique case (cmd)
      CMD_START: classified.cmd = CMD_START;
      CMD_STOP:  classified.cmd = CMD_STOP;
      CMD_WRITE: classified.cmd = CMD_WRITE;
      CMD_READ:  classified.cmd = CMD_READ;
      default:   classified.cmd = CMD_NONE;
    endcase
  end

  assign in_ready   = (count != 2'(DEPTH));
  assign push       = in_valid && in_ready;
  assign beat_valid = (count != 2'd0);
  assign pop        = beat_valid && beat_ready;
  assign beat       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/i2cm_engine.sv =====
module i2cm_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat_valid,
  output logic                 beat_ready,
  input  i2cm_pkg::tick_beat_t beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scl_pull_low,
  output logic                 sda_pull_low,
  output logic                 ready_res,
  output logic                 done_res,
  output logic [7:0]           read_data,
  output logic                 nack_received,
  output logic                 bus_held
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_RS_SCL, PH_RS_WAIT, PH_ST_SDA, PH_ST_SCL,
    PH_SP_SCL, PH_SP_WAIT, PH_SP_SDA, PH_SP_END,
    PH_W_SDA, PH_W_SCL, PH_W_WAIT, PH_WA_SDA, PH_WA_SCL, PH_WA_WAIT,
    PH_R_SDA, PH_R_SCL, PH_R_WAIT, PH_RA_SDA, PH_RA_SCL, PH_RA_WAIT
  } phase_t;

  phase_t               phase;
  cmd_t                 active_cmd;
  logic                 bus_started;
  logic [BIT_CNT_W-1:0] bit_counter;
  logic [BIT_CNT_W-1:0] bit_counter_next;
  logic [7:0]           shift_byte;
  logic                 ack_to_send;
  logic                 last_nack;
  logic                 scl_drive;
  logic                 sda_drive;
  logic [7:0]           read_reg;
  logic                 done;
  logic                 step;

  // The line state registers double as the result register: they only move
  // when a tick is taken, and a tick is taken only when the previous result
  // has left or is leaving.
  assign step             = beat_valid && (!out_valid || out_ready);
  assign beat_ready       = !out_valid || out_ready;
  assign bit_counter_next = bit_counter - BIT_CNT_W'(1);

  assign scl_pull_low  = scl_drive;
  assign sda_pull_low  = sda_drive;
  assign ready_res     = (phase == PH_IDLE);
  assign done_res      = done;
  assign read_data     = read_reg;
  assign nack_received = last_nack;
  assign bus_held      = bus_started;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase       <= PH_IDLE;
      active_cmd  <= CMD_NONE;
      bus_started <= 1'b0;
      bit_counter <= '0;
      shift_byte  <= 8'd0;
      ack_to_send <= 1'b0;
      last_nack   <= 1'b0;
      scl_drive   <= 1'b0;
      sda_drive   <= 1'b0;
      read_reg    <= 8'd0;
      done        <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
      done      <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          unique case (beat.cmd)
            CMD_START: begin
              active_cmd <= CMD_START;
              if (bus_started) begin
                sda_drive <= 1'b0;
                phase     <= PH_RS_SCL;
              end else begin
                sda_drive <= 1'b1;
                phase     <= PH_ST_SCL;
              end
            end
            CMD_STOP: begin
              active_cmd <= CMD_STOP;
              sda_drive  <= 1'b1;
              phase      <= PH_SP_SCL;
            end
            CMD_WRITE: begin
              active_cmd  <= CMD_WRITE;
              bit_counter <= BIT_COUNT_INIT;
              sda_drive   <= ~beat.write_data[7];
              shift_byte  <= {beat.write_data[6:0], 1'b0};
              phase       <= PH_W_SCL;
            end
            CMD_READ: begin
              active_cmd  <= CMD_READ;
              bit_counter <= BIT_COUNT_INIT;
              shift_byte  <= 8'd0;
              ack_to_send <= beat.send_nack;
              sda_drive   <= 1'b0;
              phase       <= PH_R_SCL;
            end
            default: begin
            end
          endcase
        end
        PH_RS_SCL: begin
          scl_drive <= 1'b0;
          phase     <= PH_RS_WAIT;
        end
        PH_RS_WAIT: begin
          if (beat.scl_level) begin
            phase <= PH_ST_SDA;
          end
        end
        PH_ST_SDA: begin
          sda_drive <= 1'b1;
          phase     <= PH_ST_SCL;
        end
        PH_ST_SCL: begin
          scl_drive   <= 1'b1;
          bus_started <= 1'b1;
          done        <= 1'b1;
          phase       <= PH_IDLE;
          active_cmd  <= CMD_NONE;
        end
        PH_SP_SCL: begin
          scl_drive <= 1'b0;
          phase     <= PH_SP_WAIT;
        end
        PH_SP_WAIT: begin
          if (beat.scl_level) begin
            phase <= PH_SP_SDA;
          end
        end
        PH_SP_SDA: begin
          sda_drive <= 1'b0;
          phase     <= PH_SP_END;
        end
        PH_SP_END: begin
          bus_started <= 1'b0;
          done        <= 1'b1;
          phase       <= PH_IDLE;
          active_cmd  <= CMD_NONE;
        end
        PH_W_SDA: begin
          sda_drive  <= ~shift_byte[7];
          shift_byte <= {shift_byte[6:0], 1'b0};
          phase      <= PH_W_SCL;
        end
        PH_W_SCL: begin
          scl_drive <= 1'b0;
          phase     <= PH_W_WAIT;
        end
        PH_W_WAIT: begin
          if (beat.scl_level) begin
            scl_drive   <= 1'b1;
            bit_counter <= bit_counter_next;
            phase       <= (bit_counter_next != '0) ? PH_W_SDA : PH_WA_SDA;
          end
        end
        PH_WA_SDA: begin
          sda_drive <= 1'b0;
          phase     <= PH_WA_SCL;
        end
        PH_WA_SCL: begin
          scl_drive <= 1'b0;
          phase     <= PH_WA_WAIT;
        end
        PH_WA_WAIT: begin
          if (beat.scl_level) begin
            last_nack  <= beat.sda_level;
            scl_drive  <= 1'b1;
            done       <= 1'b1;
            phase      <= PH_IDLE;
            active_cmd <= CMD_NONE;
          end
        end
        PH_R_SDA: begin
          sda_drive <= 1'b0;
          phase     <= PH_R_SCL;
        end
        PH_R_SCL: begin
          scl_drive <= 1'b0;
          phase     <= PH_R_WAIT;
        end
        PH_R_WAIT: begin
          if (beat.scl_level) begin
            shift_byte  <= {shift_byte[6:0], beat.sda_level};
            scl_drive   <= 1'b1;
            bit_counter <= bit_counter_next;
            phase       <= (bit_counter_next != '0) ? PH_R_SDA : PH_RA_SDA;
          end
        end
        PH_RA_SDA: begin
          sda_drive <= ~ack_to_send;
          phase     <= PH_RA_SCL;
        end
        PH_RA_SCL: begin
          scl_drive <= 1'b0;
          phase     <= PH_RA_WAIT;
        end
        PH_RA_WAIT: begin
          if (beat.scl_level) begin
            scl_drive  <= 1'b1;
            read_reg   <= shift_byte;
            done       <= 1'b1;
            phase      <= PH_IDLE;
            active_cmd <= CMD_NONE;
          end
        end
        default: begin
          phase      <= PH_IDLE;
          active_cmd <= CMD_NONE;
        end
      endcase
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`include "i2c_master_byte_engine_assert.svh"

  `I2CM_ASSERT(a_idle_matches_cmd, (phase == PH_IDLE) == (active_cmd == CMD_NONE), "idle state")
  `I2CM_ASSERT(a_done_is_idle, done |-> (phase == PH_IDLE), "done pulse outside idle")
  `I2CM_ASSERT(a_hold_phase, !step |=> $stable(phase), "phase moved without a tick")
  `I2CM_ASSERT(a_hold_lines, !step |=> $stable(scl_drive) && $stable(sda_drive), "lines moved")
  `I2CM_ASSERT(a_bit_count_range, bit_counter <= BIT_COUNT_INIT, "bit counter out of range")

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// I2C master byte engine, one bus tick per input beat and one result beat per tick.
// A tick accepted into the tick queue is then taken by the engine, which registers its result.
// Throughput: one tick per clock while out_ready holds, set by the two-entry tick queue feeding the
// phase engine, whose state registers also serve as the result register.
// Reset (rst, synchronous, active high): queue empty, engine idle, both lines
// released, bus not held, read byte and acknowledge status cleared.
module i2c_master_byte_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [7:0] write_data,
  input  logic       send_nack,
  input  logic       scl_level,
  input  logic       sda_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_pull_low,
  output logic       sda_pull_low,
  output logic       ready_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       nack_received,
  output logic       bus_held
);
  import i2cm_pkg::*;

  // Beat handoff between the front (which folds unused command codes into
  // "no command" and queues the tick) and the engine (which steps the bus
  // phase machine once per tick). The queue lets the input side keep taking
  // beats while a result beat waits on the output side.
  tick_beat_t beat;
  logic       beat_valid;
  logic       beat_ready;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .write_data (write_data),
    .send_nack  (send_nack),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat)
  );

  // The engine updates its drive and status registers on each tick it takes;
  // commands are only looked at while idle, so a command on a busy tick is
  // dropped. Wait phases repeat while the sampled SCL stays low, which gives
  // clock stretching with no timeout.
  i2cm_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .beat_valid    (beat_valid),
    .beat_ready    (beat_ready),
    .beat          (beat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .scl_pull_low  (scl_pull_low),
    .sda_pull_low  (sda_pull_low),
    .ready_res     (ready_res),
    .done_res      (done_res),
    .read_data     (read_data),
    .nack_received (nack_received),
    .bus_held      (bus_held)
  );

endmodule
